@@ src/rfrc_pkg.sv @@
// ----------------------------------------------------------------------------
// rfrc_pkg
// Shared types and constants for the response frame receiver and classifier.
// ----------------------------------------------------------------------------
package rfrc_pkg;

   // Default sizes handed to the top level parameters.
   localparam int unsigned DEF_STORE_DEPTH = 256;
   localparam int unsigned DEF_HEADER_LEN  = 8;

   // Field widths fixed by the interface.
   localparam int unsigned ACTION_W = 2;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned LEN_W    = 9;
   localparam int unsigned OUTC_W   = 3;
   localparam int unsigned PLEN_W   = 16;
   localparam int unsigned CSR_IDX_W = 3;

   // Request actions.
   localparam logic [ACTION_W-1:0] ACT_RX      = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ    = 2'd2;

   // Frame outcomes.
   localparam logic [OUTC_W-1:0] OUT_RECEIVING   = 3'd0;
   localparam logic [OUTC_W-1:0] OUT_SUCCESS     = 3'd1;
   localparam logic [OUTC_W-1:0] OUT_WAIT        = 3'd2;
   localparam logic [OUTC_W-1:0] OUT_ERROR       = 3'd3;
   localparam logic [OUTC_W-1:0] OUT_UNSUPPORTED = 3'd4;
   localparam logic [OUTC_W-1:0] OUT_FULL        = 3'd5;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_START_BYTE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SUCCESS_CODE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WAIT_CODE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ERR_LOW      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ERR_HIGH     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SUCCESS_LEN  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_WAIT_LEN     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_ERR_LEN      = 3'd7;

   // Header layout and payload lengths of the known frame classes.
   localparam int unsigned LEN_HI_POS = 5;
   localparam int unsigned LEN_LO_POS = 6;
   localparam int unsigned CODE_POS   = 7;
   localparam logic [PLEN_W-1:0] MIN_SUCCESS_PAYLOAD = 16'd26;
   localparam logic [PLEN_W-1:0] WAIT_PAYLOAD        = 16'd2;
   localparam logic [PLEN_W-1:0] ERROR_PAYLOAD       = 16'd1;

   typedef struct packed {
      logic [BYTE_W-1:0] start_byte;
      logic [BYTE_W-1:0] success_code;
      logic [BYTE_W-1:0] wait_code;
      logic [BYTE_W-1:0] err_low;
      logic [BYTE_W-1:0] err_high;
      logic [LEN_W-1:0]  success_len;
      logic [LEN_W-1:0]  wait_len;
      logic [LEN_W-1:0]  err_len;
   } cfg_type;

   typedef struct packed {
      logic              done;
      logic [OUTC_W-1:0] outcome;
      logic [BYTE_W-1:0] ret_code;
      logic [LEN_W-1:0]  count;
   } stat_type;

endpackage

@@ src/rfrc_store.sv @@
// ----------------------------------------------------------------------------
// rfrc_store
// Frame byte memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
module rfrc_store #(
   parameter int unsigned DEPTH  = rfrc_pkg::DEF_STORE_DEPTH,
   parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [rfrc_pkg::BYTE_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [rfrc_pkg::BYTE_W-1:0] rd_data
);
   import rfrc_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/rfrc_ctrl.sv @@
// ----------------------------------------------------------------------------
// rfrc_ctrl
// Frame state tracking, store write addressing and frame classification.
// ----------------------------------------------------------------------------
module rfrc_ctrl #(
   parameter int unsigned STORE_DEPTH = rfrc_pkg::DEF_STORE_DEPTH,
   parameter int unsigned HEADER_LEN  = rfrc_pkg::DEF_HEADER_LEN,
   parameter int unsigned ADDR_W      = $clog2(STORE_DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [rfrc_pkg::ACTION_W-1:0] action,
   input  logic [rfrc_pkg::BYTE_W-1:0]   rx_byte,
   input  rfrc_pkg::cfg_type             cfg,
   output rfrc_pkg::stat_type            stat_next,
   output logic                          wr_en,
   output logic [ADDR_W-1:0]             wr_addr,
   output logic [rfrc_pkg::BYTE_W-1:0]   wr_data
);
   import rfrc_pkg::*;

   localparam int unsigned CNT_W = $clog2(STORE_DEPTH + 1);
   localparam int unsigned CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

   logic [CNT_W-1:0]  count_ff, count_in, cnt_new;
   logic              done_ff, done_in;
   logic [OUTC_W-1:0] outcome_ff, outcome_in;
   logic [PLEN_W-1:0] plen_ff, plen_in;
   logic [BYTE_W-1:0] ret_ff, ret_in;
   // Copies of the header bytes as they are written to the store, so that
   // classification does not need extra read ports on the memory.
   logic [BYTE_W-1:0] hdr_hi_ff, hdr_hi_in;
   logic [BYTE_W-1:0] hdr_lo_ff, hdr_lo_in;
   logic [BYTE_W-1:0] hdr_code_ff, hdr_code_in;
   logic [PLEN_W-1:0] eff_plen;
   logic [CMP_W-1:0]  cnt_cmp;
   logic              is_success, is_wait, is_error;

   assign cnt_new = count_ff + CNT_W'(1);
   assign cnt_cmp = CMP_W'(cnt_new);

   always_comb begin
      hdr_hi_in   = (count_ff == CNT_W'(LEN_HI_POS)) ? rx_byte : hdr_hi_ff;
      hdr_lo_in   = (count_ff == CNT_W'(LEN_LO_POS)) ? rx_byte : hdr_lo_ff;
      hdr_code_in = (count_ff == CNT_W'(CODE_POS))   ? rx_byte : hdr_code_ff;
      eff_plen    = {hdr_hi_in, hdr_lo_in};
      is_success  = (eff_plen >= MIN_SUCCESS_PAYLOAD) && (hdr_code_in == cfg.success_code);
      is_wait     = (eff_plen == WAIT_PAYLOAD) && (hdr_code_in == cfg.wait_code);
      is_error    = (eff_plen == ERROR_PAYLOAD) && (hdr_code_in >= cfg.err_low) &&
                    (hdr_code_in <= cfg.err_high);
   end

   always_comb begin
      count_in   = count_ff;
      done_in    = done_ff;
      outcome_in = outcome_ff;
      plen_in    = plen_ff;
      ret_in     = ret_ff;
      wr_en      = 1'b0;
      wr_addr    = ADDR_W'(count_ff);
      wr_data    = rx_byte;
      case (action)
         ACT_RX: begin
            if (!done_ff) begin
               if (count_ff >= CNT_W'(STORE_DEPTH)) begin
                  done_in    = 1'b1;
                  outcome_in = OUT_FULL;
               end else if (count_ff == '0) begin
                  if (rx_byte == cfg.start_byte) begin
                     wr_en    = 1'b1;
                     count_in = cnt_new;
                  end
               end else begin
                  wr_en    = 1'b1;
                  count_in = cnt_new;
                  if (cnt_new >= CNT_W'(HEADER_LEN)) begin
                     plen_in = eff_plen;
                     ret_in  = hdr_code_in;
                     if (is_success) begin
                        if (cnt_cmp >= CMP_W'(cfg.success_len)) begin
                           done_in    = 1'b1;
                           outcome_in = OUT_SUCCESS;
                        end
                     end else if (is_wait) begin
                        if (cnt_cmp >= CMP_W'(cfg.wait_len)) begin
                           done_in    = 1'b1;
                           outcome_in = OUT_WAIT;
                        end
                     end else if (is_error) begin
                        if (cnt_cmp >= CMP_W'(cfg.err_len)) begin
                           done_in    = 1'b1;
                           outcome_in = OUT_ERROR;
                        end
                     end else begin
                        done_in    = 1'b1;
                        outcome_in = OUT_UNSUPPORTED;
                     end
                  end
               end
            end
         end
         ACT_RELEASE: begin
            count_in   = '0;
            done_in    = 1'b0;
            outcome_in = OUT_RECEIVING;
            plen_in    = '0;
            ret_in     = '0;
         end
         default: begin
         end
      endcase
      wr_en = wr_en && accept;
   end

   always_comb begin
      stat_next.done     = done_in;
      stat_next.outcome  = outcome_in;
      stat_next.ret_code = ret_in;
      stat_next.count    = LEN_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         done_ff    <= 1'b0;
         outcome_ff <= OUT_RECEIVING;
         plen_ff    <= '0;
         ret_ff     <= '0;
      end else if (accept) begin
         count_ff   <= count_in;
         done_ff    <= done_in;
         outcome_ff <= outcome_in;
         plen_ff    <= plen_in;
         ret_ff     <= ret_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hdr_hi_ff   <= hdr_hi_in;
         hdr_lo_ff   <= hdr_lo_in;
         hdr_code_ff <= hdr_code_in;
      end
   end

   a_done_has_outcome: assert property (@(posedge clock) disable iff (reset)
      done_ff == (outcome_ff != OUT_RECEIVING))
      else $error("frame done flag and outcome disagree");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STORE_DEPTH))
      else $error("stored byte count beyond store depth");

   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && action == ACT_RELEASE) |=> (count_ff == '0 && !done_ff && ret_ff == '0))
      else $error("release did not clear the frame state");

   a_no_write_when_done: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !wr_en)
      else $error("store written after the frame ended");

endmodule

@@ src/response_frame_receiver_classifier.sv @@
// ----------------------------------------------------------------------------
// response_frame_receiver_classifier
// Collects serial response bytes into a frame store, classifies the frame
// from its header and reports the frame state for every request.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Payload
//  req_*     in         req_valid/req_ready    action, rx_byte, read_index
//  rsp_*     out        rsp_valid/rsp_ready    frame_done, outcome, return_code,
//                                              byte_count, read_data
//  csr_*     in         csr_wr_en (no wait)    csr_index, csr_wr_data
//
//  One request is taken per clock cycle while the response side keeps up,
//  and every request yields one response. Each response passes through the
//  read stage with the store's registered read port, then the output register.
//  Reset is synchronous and clears all frame state and loads the register
//  defaults; the frame store needs no clearing pass and is ready at once.
//  When rsp_ready is low the block still takes one more request into its
//  read stage and then holds req_ready low until the output register drains.
//
module response_frame_receiver_classifier #(
   parameter int unsigned STORE_DEPTH = rfrc_pkg::DEF_STORE_DEPTH,
   parameter int unsigned HEADER_LEN  = rfrc_pkg::DEF_HEADER_LEN
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel.
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [rfrc_pkg::ACTION_W-1:0]  req_action,
   input  logic [rfrc_pkg::BYTE_W-1:0]    req_rx_byte,
   input  logic [rfrc_pkg::BYTE_W-1:0]    req_read_index,
   // Response channel.
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_frame_done,
   output logic [rfrc_pkg::OUTC_W-1:0]    rsp_outcome,
   output logic [rfrc_pkg::BYTE_W-1:0]    rsp_return_code,
   output logic [rfrc_pkg::LEN_W-1:0]     rsp_byte_count,
   output logic [rfrc_pkg::BYTE_W-1:0]    rsp_read_data,
   // Configuration write port.
   input  logic                           csr_wr_en,
   input  logic [rfrc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rfrc_pkg::LEN_W-1:0]     csr_wr_data
);
   import rfrc_pkg::*;

   localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);

   // Configuration registers, reset to their documented defaults.
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte   <= 8'd2;
         cfg_ff.success_code <= 8'd0;
         cfg_ff.wait_code    <= 8'd1;
         cfg_ff.err_low      <= 8'd2;
         cfg_ff.err_high     <= 8'd3;
         cfg_ff.success_len  <= 9'd36;
         cfg_ff.wait_len     <= 9'd10;
         cfg_ff.err_len      <= 9'd9;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_START_BYTE:   cfg_ff.start_byte   <= csr_wr_data[BYTE_W-1:0];
            REG_SUCCESS_CODE: cfg_ff.success_code <= csr_wr_data[BYTE_W-1:0];
            REG_WAIT_CODE:    cfg_ff.wait_code    <= csr_wr_data[BYTE_W-1:0];
            REG_ERR_LOW:      cfg_ff.err_low      <= csr_wr_data[BYTE_W-1:0];
            REG_ERR_HIGH:     cfg_ff.err_high     <= csr_wr_data[BYTE_W-1:0];
            REG_SUCCESS_LEN:  cfg_ff.success_len  <= csr_wr_data;
            REG_WAIT_LEN:     cfg_ff.wait_len     <= csr_wr_data;
            REG_ERR_LEN:      cfg_ff.err_len      <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   // Pipeline handshake. Stage one holds a request while its store read is
   // in flight; the output register holds the finished response. Stage one
   // drains whenever the output register is empty or being taken.
   logic     accept;
   logic     s1_vld_ff, s1_vld_in;
   logic     s1_move;
   logic     rsp_vld_ff, rsp_vld_in;
   stat_type s1_stat_ff;
   logic     s1_rd_sel_ff;
   stat_type stat_next;
   logic     rd_req, rd_in_range;

   assign s1_move   = s1_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !s1_vld_ff || s1_move;
   assign accept    = req_valid && req_ready;

   // A read beyond the store depth answers zero.
   assign rd_in_range = (32'(req_read_index) < 32'(STORE_DEPTH));
   assign rd_req      = accept && (req_action == ACT_READ);

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [BYTE_W-1:0] wr_data;
   logic [BYTE_W-1:0] rd_data;

   rfrc_ctrl #(
      .STORE_DEPTH (STORE_DEPTH),
      .HEADER_LEN  (HEADER_LEN),
      .ADDR_W      (ADDR_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .action    (req_action),
      .rx_byte   (req_rx_byte),
      .cfg       (cfg_ff),
      .stat_next (stat_next),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   // A write and a later read of the same entry never collide: the write
   // lands at the edge that accepts the byte, before any later read is issued.
   rfrc_store #(
      .DEPTH  (STORE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_req),
      .rd_addr (ADDR_W'(req_read_index)),
      .rd_data (rd_data)
   );

   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (accept) begin
         s1_vld_in = 1'b1;
      end else if (s1_move) begin
         s1_vld_in = 1'b0;
      end
      rsp_vld_in = rsp_vld_ff;
      if (s1_move) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // The status captured here is the frame state after the request's update.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_stat_ff   <= stat_next;
         s1_rd_sel_ff <= (req_action == ACT_READ) && rd_in_range;
      end
   end

   // The store's read register only changes on a new read request, so it
   // holds its data while stage one waits.
   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_frame_done  <= s1_stat_ff.done;
         rsp_outcome     <= s1_stat_ff.outcome;
         rsp_return_code <= s1_stat_ff.ret_code;
         rsp_byte_count  <= s1_stat_ff.count;
         rsp_read_data   <= s1_rd_sel_ff ? rd_data : '0;
      end
   end

   assign rsp_valid = rsp_vld_ff;

   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_vld_ff)
      else $error("accepted request did not enter the read stage");

   a_s1_move_fills_out: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> rsp_vld_ff)
      else $error("read stage advanced without filling the output register");

   a_no_accept_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && rsp_vld_ff && !rsp_ready) |-> !accept)
      else $error("request accepted while both stages were blocked");

endmodule

@@ tb/response_frame_receiver_classifier_tb.sv @@
// ----------------------------------------------------------------------------
// response_frame_receiver_classifier_tb
// Self-checking testbench for the response frame receiver and classifier.
// Requests are driven with random gaps and the response side stalls at random.
// Every accepted request updates a cycle-free model of the frame state, and
// every accepted response is compared field by field with the oldest pending
// prediction. Several register settings are exercised, the extremes among
// them, so that every frame class, the store full case and the empty error
// range are reached.
// ----------------------------------------------------------------------------
module response_frame_receiver_classifier_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rfrc_pkg::*;

   localparam int unsigned STORE_DEPTH = DEF_STORE_DEPTH;
   localparam int unsigned HEADER_LEN  = DEF_HEADER_LEN;

   // The action code that the block must ignore.
   localparam logic [ACTION_W-1:0] ACT_RESERVED = 2'd3;

   localparam int unsigned DRAIN_CYCLES    = 8;
   localparam int unsigned HOLD_OFF_CYCLES = 64;
   localparam int unsigned WATCHDOG_LIMIT  = 2000;
   localparam int unsigned MAX_REPORTS     = 40;

   // One response as it appears on the rsp_* ports.
   typedef struct packed {
      logic              done;
      logic [OUTC_W-1:0] outcome;
      logic [BYTE_W-1:0] ret_code;
      logic [LEN_W-1:0]  count;
      logic [BYTE_W-1:0] read_data;
   } frame_status_type;

   // Shapes of frame that the stimulus can build.
   typedef enum {FR_SUCCESS, FR_WAIT, FR_ERROR, FR_OTHER, FR_BROKEN} frame_kind_type;

   // -------------------------------------------------------------------------
   // Scoreboard: keeps its own copy of the frame state and the registers,
   // predicts the response of each accepted request and checks the
   // responses in order.
   // -------------------------------------------------------------------------
   class frame_scoreboard;
      cfg_type           cfg;
      logic [BYTE_W-1:0] store [STORE_DEPTH];
      bit                written [STORE_DEPTH];
      logic [BYTE_W-1:0] written_idx [$];
      logic [LEN_W-1:0]  count;
      logic              done;
      logic [OUTC_W-1:0] outcome;
      logic [PLEN_W-1:0] plen;
      logic [BYTE_W-1:0] code;
      frame_status_type  expected_status [$];
      int unsigned       errors;
      int unsigned       checked;

      function new();
         cfg = '{start_byte: 8'd2, success_code: 8'd0, wait_code: 8'd1,
                 err_low: 8'd2, err_high: 8'd3,
                 success_len: 9'd36, wait_len: 9'd10, err_len: 9'd9};
         clear_frame();
         errors  = 0;
         checked = 0;
      endfunction

      function void clear_frame();
         count   = '0;
         done    = 1'b0;
         outcome = OUT_RECEIVING;
         plen    = '0;
         code    = '0;
      endfunction

      function void end_frame(logic [OUTC_W-1:0] result);
         done    = 1'b1;
         outcome = result;
      endfunction

      function void store_byte(logic [BYTE_W-1:0] b);
         store[count[BYTE_W-1:0]] = b;
         if (!written[count[BYTE_W-1:0]]) begin
            written[count[BYTE_W-1:0]] = 1'b1;
            written_idx.push_back(count[BYTE_W-1:0]);
         end
         count++;
      endfunction

      // Classes are tried in a fixed order; a known class only ends the
      // frame once its configured length is reached.
      function void classify_frame();
         plen = {store[LEN_HI_POS], store[LEN_LO_POS]};
         code = store[CODE_POS];
         if (plen >= MIN_SUCCESS_PAYLOAD && code == cfg.success_code) begin
            if (count >= cfg.success_len) end_frame(OUT_SUCCESS);
         end else if (plen == WAIT_PAYLOAD && code == cfg.wait_code) begin
            if (count >= cfg.wait_len) end_frame(OUT_WAIT);
         end else if (plen == ERROR_PAYLOAD && code >= cfg.err_low && code <= cfg.err_high) begin
            if (count >= cfg.err_len) end_frame(OUT_ERROR);
         end else begin
            end_frame(OUT_UNSUPPORTED);
         end
      endfunction

      function void take_byte(logic [BYTE_W-1:0] b);
         if (done) return;
         if (count >= STORE_DEPTH) begin
            end_frame(OUT_FULL);
            return;
         end
         if (count == 0) begin
            if (b == cfg.start_byte) store_byte(b);
            return;
         end
         store_byte(b);
         if (count >= HEADER_LEN) classify_frame();
      endfunction

      function void note_request(logic [ACTION_W-1:0] act, logic [BYTE_W-1:0] rx,
                                 logic [BYTE_W-1:0] idx);
         frame_status_type s;
         logic [BYTE_W-1:0] rdata;
         rdata = '0;
         case (act)
            ACT_RX:      take_byte(rx);
            ACT_RELEASE: clear_frame();
            ACT_READ:    if (idx < STORE_DEPTH) rdata = store[idx];
            default:     ;
         endcase
         s.done      = done;
         s.outcome   = outcome;
         s.ret_code  = code;
         s.count     = count;
         s.read_data = rdata;
         expected_status.push_back(s);
      endfunction

      task report(string msg);
         errors++;
         if (errors <= MAX_REPORTS) $display("ERROR response %0d: %s", checked, msg);
      endtask

      task check_field(string name, logic [LEN_W-1:0] got, logic [LEN_W-1:0] want);
         if (got !== want) report($sformatf("%s got 0x%0h, predicted 0x%0h", name, got, want));
      endtask

      task check_response(frame_status_type got);
         frame_status_type want;
         checked++;
         if (expected_status.size() == 0) begin
            report("response arrived with no request outstanding");
            return;
         end
         want = expected_status.pop_front();
         check_field("frame_done", LEN_W'(got.done), LEN_W'(want.done));
         check_field("outcome", LEN_W'(got.outcome), LEN_W'(want.outcome));
         check_field("return_code", LEN_W'(got.ret_code), LEN_W'(want.ret_code));
         check_field("byte_count", got.count, want.count);
         check_field("read_data", LEN_W'(got.read_data), LEN_W'(want.read_data));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, DUT and monitors.
   // -------------------------------------------------------------------------
   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_ready;
   logic [ACTION_W-1:0]   req_action     = ACT_RX;
   logic [BYTE_W-1:0]     req_rx_byte    = '0;
   logic [BYTE_W-1:0]     req_read_index = '0;
   logic                  rsp_valid;
   logic                  rsp_ready      = 1'b0;
   logic                  rsp_frame_done;
   logic [OUTC_W-1:0]     rsp_outcome;
   logic [BYTE_W-1:0]     rsp_return_code;
   logic [LEN_W-1:0]      rsp_byte_count;
   logic [BYTE_W-1:0]     rsp_read_data;
   logic                  csr_wr_en      = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index      = REG_START_BYTE;
   logic [LEN_W-1:0]      csr_wr_data    = '0;

   // Stimulus knobs shared with the response side.
   bit          no_gaps      = 1'b0;
   bit          hold_off_req = 1'b0;
   int unsigned sent_items   = 0;

   frame_scoreboard sb = new();

   always #1 clock = ~clock;

   response_frame_receiver_classifier #(
      .STORE_DEPTH (STORE_DEPTH),
      .HEADER_LEN  (HEADER_LEN)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_rx_byte     (req_rx_byte),
      .req_read_index  (req_read_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_frame_done  (rsp_frame_done),
      .rsp_outcome     (rsp_outcome),
      .rsp_return_code (rsp_return_code),
      .rsp_byte_count  (rsp_byte_count),
      .rsp_read_data   (rsp_read_data),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   // Both handshakes are sampled at the rising edge. A request is noted
   // before a response is checked, so a response that leaves in the same
   // cycle as its own request would still find its prediction waiting.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(req_action, req_rx_byte, req_read_index);
         if (rsp_valid && rsp_ready)
            sb.check_response(frame_status_type'{rsp_frame_done, rsp_outcome, rsp_return_code,
                                                 rsp_byte_count, rsp_read_data});
      end
   end

   // The response side stalls at random, about 7 times in 100. When a hold-off is
   // requested it keeps rsp_ready low for a long stretch, counted here, so
   // the block fills up and has to push back on its request side.
   initial begin : response_sink
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= no_gaps || ($urandom_range(99) >= 7);
         end
      end
   end

   // Ends the run when nothing has moved on either channel for too long.
   initial begin : watchdog
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("response_frame_receiver_classifier_tb: FAIL");
      $finish;
   end

   // A random byte value.
   function automatic logic [BYTE_W-1:0] rand_byte();
      return BYTE_W'($urandom_range(255));
   endfunction

   // -------------------------------------------------------------------------
   // Driving tasks. All of them are entered and left at a falling edge.
   // -------------------------------------------------------------------------

   // Offers one request and waits until it is accepted. Valid stays high
   // between back-to-back requests; a gap, when taken, comes before the
   // payload changes so that valid never drops under a pending request.
   task automatic send_request(input logic [ACTION_W-1:0] act, input logic [BYTE_W-1:0] rx,
                               input logic [BYTE_W-1:0] idx);
      int unsigned gap;
      gap = 0;
      if (!no_gaps && $urandom_range(99) < 7) gap = 1;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_rx_byte    <= rx;
      req_read_index <= idx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (act != ACT_RESERVED) sent_items++;
   endtask

   // Reads back one entry that has been written at some point. Entries that
   // were never written are never read.
   task automatic read_back();
      if (sb.written_idx.size() != 0)
         send_request(ACT_READ, rand_byte(),
                      sb.written_idx[$urandom_range(sb.written_idx.size() - 1)]);
   endtask

   // Lowers valid and waits until every predicted response has been seen,
   // then lets the pipeline settle.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.expected_status.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic put_csr(input logic [CSR_IDX_W-1:0] idx, input logic [LEN_W-1:0] data);
      csr_index   <= idx;
      csr_wr_data <= data;
      @(negedge clock);
   endtask

   // Writes every register. Only called while the block is idle.
   task automatic load_config(input cfg_type c);
      csr_wr_en <= 1'b1;
      put_csr(REG_START_BYTE,   {1'b0, c.start_byte});
      put_csr(REG_SUCCESS_CODE, {1'b0, c.success_code});
      put_csr(REG_WAIT_CODE,    {1'b0, c.wait_code});
      put_csr(REG_ERR_LOW,      {1'b0, c.err_low});
      put_csr(REG_ERR_HIGH,     {1'b0, c.err_high});
      put_csr(REG_SUCCESS_LEN,  c.success_len);
      put_csr(REG_WAIT_LEN,     c.wait_len);
      put_csr(REG_ERR_LEN,      c.err_len);
      csr_wr_en <= 1'b0;
      sb.cfg = c;
   endtask

   // Random register set with short class lengths. The error range is left
   // empty now and then.
   function automatic cfg_type random_config();
      cfg_type c;
      logic [BYTE_W-1:0] t;
      c.start_byte   = rand_byte();
      c.success_code = rand_byte();
      c.wait_code    = rand_byte();
      c.err_low      = rand_byte();
      c.err_high     = rand_byte();
      if (c.err_low > c.err_high && $urandom_range(3) != 0) begin
         t          = c.err_low;
         c.err_low  = c.err_high;
         c.err_high = t;
      end
      c.success_len = LEN_W'($urandom_range(40, 8));
      c.wait_len    = LEN_W'($urandom_range(40, 8));
      c.err_len     = LEN_W'($urandom_range(40, 8));
      return c;
   endfunction

   // Sends one frame built for the current registers: a little line noise,
   // the start byte, a header aimed at the given class, body bytes up to the
   // class length and a few bytes past the end that must be dropped. Reads
   // are mixed in, and the frame is always released at the end. A broken
   // frame is cut off at a random point.
   task automatic send_frame(input frame_kind_type kind);
      logic [PLEN_W-1:0] plen;
      logic [BYTE_W-1:0] code;
      logic [BYTE_W-1:0] b;
      int unsigned total;
      plen  = PLEN_W'($urandom_range(65535));
      code  = rand_byte();
      total = HEADER_LEN;
      case (kind)
         FR_SUCCESS: begin
            case ($urandom_range(2))
               0:       plen = MIN_SUCCESS_PAYLOAD;
               1:       plen = '1;
               default: plen = PLEN_W'($urandom_range(65535, MIN_SUCCESS_PAYLOAD));
            endcase
            code  = sb.cfg.success_code;
            total = 32'(sb.cfg.success_len);
         end
         FR_WAIT: begin
            plen  = WAIT_PAYLOAD;
            code  = sb.cfg.wait_code;
            total = 32'(sb.cfg.wait_len);
         end
         FR_ERROR: begin
            plen = ERROR_PAYLOAD;
            // With an empty range the frame is unsupported and ends at the
            // header, so there is no point sending a long body.
            if (sb.cfg.err_low <= sb.cfg.err_high) begin
               code  = BYTE_W'($urandom_range(sb.cfg.err_high, sb.cfg.err_low));
               total = 32'(sb.cfg.err_len);
            end
         end
         FR_OTHER: if ($urandom_range(1) != 0) plen = PLEN_W'($urandom_range(3));
         default:  total = $urandom_range(HEADER_LEN + 4, 1);
      endcase
      if (kind != FR_BROKEN) begin
         if (total < HEADER_LEN) total = HEADER_LEN;
         // A class length beyond the store runs into the store full case.
         if (total > STORE_DEPTH) total = STORE_DEPTH + 1;
         total += $urandom_range(2);
      end
      for (int i = $urandom_range(2); i > 0; i--) begin
         b = rand_byte();
         if (b == sb.cfg.start_byte) b = ~b;
         send_request(ACT_RX, b, rand_byte());
      end
      for (int unsigned pos = 0; pos < total; pos++) begin
         case (pos)
            0:          b = sb.cfg.start_byte;
            LEN_HI_POS: b = plen[15:8];
            LEN_LO_POS: b = plen[7:0];
            CODE_POS:   b = code;
            default:    b = rand_byte();
         endcase
         send_request(ACT_RX, b, rand_byte());
         if ($urandom_range(99) < 8) read_back();
      end
      repeat ($urandom_range(2)) read_back();
      if ($urandom_range(9) == 0)
         send_request(ACT_RESERVED, rand_byte(), rand_byte());
      send_request(ACT_RELEASE, rand_byte(), rand_byte());
   endtask

   // Sends frames of random class until the request count reaches target.
   task automatic send_random_frames(input int unsigned target);
      int unsigned r;
      while (sent_items < target) begin
         r = $urandom_range(99);
         if (r < 25)      send_frame(FR_SUCCESS);
         else if (r < 45) send_frame(FR_WAIT);
         else if (r < 65) send_frame(FR_ERROR);
         else if (r < 80) send_frame(FR_OTHER);
         else             send_frame(FR_BROKEN);
      end
   endtask

   // -------------------------------------------------------------------------
   // Test sequence.
   // -------------------------------------------------------------------------
   initial begin : stimulus
      cfg_type c;
      logic [BYTE_W-1:0] wait_frame [10];
      logic [BYTE_W-1:0] odd_frame [8];

      // Hold reset and release it at a falling edge.
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, run with the register defaults (start byte 2, wait
      // code 1, wait frames ten bytes long).
      // Bytes other than the start byte are ignored while the store is empty.
      send_request(ACT_RX, 8'h00, 8'h00);
      send_request(ACT_RX, 8'hFF, 8'hFF);
      // A wait frame: payload length 2 and the wait code. It is still open
      // after the header and ends on its tenth byte.
      wait_frame[0] = 8'h02;
      wait_frame[1] = 8'h11;
      wait_frame[2] = 8'h22;
      wait_frame[3] = 8'h33;
      wait_frame[4] = 8'h44;
      wait_frame[5] = 8'h00;
      wait_frame[6] = 8'h02;
      wait_frame[7] = 8'h01;
      wait_frame[8] = 8'h5A;
      wait_frame[9] = 8'hA5;
      foreach (wait_frame[i]) send_request(ACT_RX, wait_frame[i], rand_byte());
      // A byte after the end of the frame is dropped.
      send_request(ACT_RX, 8'hFF, 8'h00);
      send_request(ACT_READ, 8'h00, 8'h00);
      send_request(ACT_READ, 8'hFF, 8'h07);
      // The unused action must leave everything alone.
      send_request(ACT_RESERVED, 8'hFF, 8'hFF);
      send_request(ACT_RELEASE, 8'h00, 8'h00);
      // A header that fits no class ends the frame at once as unsupported.
      odd_frame[0] = 8'h02;
      odd_frame[1] = 8'h01;
      odd_frame[2] = 8'h02;
      odd_frame[3] = 8'h03;
      odd_frame[4] = 8'h04;
      odd_frame[5] = 8'h00;
      odd_frame[6] = 8'h00;
      odd_frame[7] = 8'hFF;
      foreach (odd_frame[i]) send_request(ACT_RX, odd_frame[i], rand_byte());
      settle();

      // Random registers with short class lengths.
      load_config(random_config());
      send_random_frames(sent_items + 40);
      settle();

      // Low extremes: every class ends on the byte that completes the
      // header, and the error range spans every code.
      c = '{start_byte: 8'hFF, success_code: 8'hFF, wait_code: 8'h00,
            err_low: 8'h00, err_high: 8'hFF,
            success_len: 9'd8, wait_len: 9'd8, err_len: 9'd8};
      load_config(c);
      send_random_frames(sent_items + 25);
      settle();

      // High extremes: a wait length shorter than the header and an empty
      // error range.
      c = '{start_byte: 8'h00, success_code: 8'h00, wait_code: 8'hFF,
            err_low: 8'd200, err_high: 8'd100,
            success_len: 9'd256, wait_len: 9'd5, err_len: 9'd256};
      load_config(c);
      send_frame(FR_WAIT);
      send_frame(FR_ERROR);
      settle();

      // A success length beyond the store: the frame fills the whole store
      // and ends as store full. Both sides run without any gaps through
      // this long frame.
      c.success_len = 9'd300;
      load_config(c);
      no_gaps = 1'b1;
      send_frame(FR_SUCCESS);
      no_gaps = 1'b0;
      // Release keeps the store, so both ends of it can still be read.
      send_request(ACT_READ, 8'h00, 8'hFF);
      send_request(ACT_READ, 8'hFF, 8'h00);
      settle();

      // Random registers again. Partway through, the response side holds
      // off for a long stretch while requests keep coming.
      load_config(random_config());
      send_random_frames(sent_items + 15);
      hold_off_req = 1'b1;
      send_random_frames(sent_items + 15);
      settle();

      if (sb.expected_status.size() != 0)
         sb.report("requests left without a response at the end of the run");
      if (sb.errors == 0)
         $display("response_frame_receiver_classifier_tb: PASS");
      else
         $display("response_frame_receiver_classifier_tb: FAIL");
      $finish;
   end

endmodule
